@@ rtl/tsg_pkg.sv @@
// shared constants and types for the triangle span generator
package tsg_pkg;

    localparam int TSG_COORD_WIDTH = 15;
    localparam int CFG_W           = 13;
    localparam int COL_W           = 12;
    localparam int COLOR_W         = 16;
    localparam int MAX_SCREEN      = 4096;
    localparam int RESET_WIDTH     = 240;
    localparam int RESET_HEIGHT    = 320;

    typedef enum logic [0:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

endpackage

@@ rtl/triangle_span_generator.sv @@
// top level of the triangle span generator
//
// Scanline fill of one triangle. A load transaction (cmd 0) brings three
// vertices and a colour; it sorts the vertices by y and gives no result.
// Each tick transaction (cmd 1) then gives one span, top row first;
// last_span marks the bottom row. A tick with no active triangle gives nothing.
// A tick goes through a start state, the two bit-serial edge dividers
// running side by side, a wait state that sees them done and an emit state
// that clips and registers the span; the next transaction is accepted once
// the emit state returns to idle. A flat triangle (all vertices on one row)
// skips the dividers and goes straight to the emit state. A load leaves
// the sequencer idle. One transaction is in work at a time; input ready is
// high only while idle. The result sits in an output register, so the next
// transaction is accepted while a span still waits; a finished span waits
// for a stalled receiver.
// Reset: screen 240 x 320, no active triangle, output empty.
// Configuration writes take effect at once; the user must make them only
// while idle: the block itself does not enforce this.
module triangle_span_generator import tsg_pkg::*; #(
    parameter int COORD_WIDTH = TSG_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic signed [COORD_WIDTH-1:0] i_vert0_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert0_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert1_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert1_y,
    input  logic signed [COORD_WIDTH-1:0] i_vert2_x,
    input  logic signed [COORD_WIDTH-1:0] i_vert2_y,
    input  logic [COLOR_W-1:0]            i_fill_color,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_span_row,
    output logic [COL_W-1:0]              o_span_left,
    output logic [COL_W-1:0]              o_span_right,
    output logic                          o_visible,
    output logic [COLOR_W-1:0]            o_span_color,
    output logic                          o_last_span
);
    localparam int CW = COORD_WIDTH;
    localparam int AW = 2 * CW + 2;
    localparam int DW = CW + 1;
    localparam int XW = CW + 2;

    typedef enum logic [1:0] {PH_IDLE, PH_UPPER, PH_LOWER, PH_FLAT} t_phase;
    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_EMIT} t_state;

    t_state               r_state;
    t_phase               r_phase;
    logic [CFG_W-1:0]     r_width, r_height;
    logic signed [CW-1:0] r_vx [3];
    logic signed [CW-1:0] r_vy [3];
    logic signed [AW-1:0] r_lacc, r_racc;
    logic signed [CW-1:0] r_row, r_uend;
    logic [COLOR_W-1:0]   r_color;
    logic                 r_out_valid;

    logic                 w_accept, w_emit, w_last;
    logic signed [CW-1:0] s_x [3];
    logic signed [CW-1:0] s_y [3];
    logic signed [CW-1:0] t_x, t_y;
    logic signed [DW-1:0] w_dyl, w_dyr, w_dxl, w_dxr, w_ql, w_qr;
    logic signed [CW-1:0] w_xs, w_fmin, w_fmax;
    logic signed [XW-1:0] w_a, w_b;
    logic signed [CW:0]   w_next_row;
    logic                 w_busy_l, w_busy_r;
    logic [COL_W-1:0]     w_left, w_right;
    logic                 w_vis;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // three stable compare-swaps on y
    always_comb begin
        t_x = '0;
        t_y = '0;
        s_x[0] = i_vert0_x; s_y[0] = i_vert0_y;
        s_x[1] = i_vert1_x; s_y[1] = i_vert1_y;
        s_x[2] = i_vert2_x; s_y[2] = i_vert2_y;
        if (s_y[0] > s_y[1]) begin
            t_x = s_x[0]; t_y = s_y[0];
            s_x[0] = s_x[1]; s_y[0] = s_y[1];
            s_x[1] = t_x; s_y[1] = t_y;
        end
        if (s_y[1] > s_y[2]) begin
            t_x = s_x[1]; t_y = s_y[1];
            s_x[1] = s_x[2]; s_y[1] = s_y[2];
            s_x[2] = t_x; s_y[2] = t_y;
        end
        if (s_y[0] > s_y[1]) begin
            t_x = s_x[0]; t_y = s_y[0];
            s_x[0] = s_x[1]; s_y[0] = s_y[1];
            s_x[1] = t_x; s_y[1] = t_y;
        end
    end

    // edge slopes and heights
    always_comb begin
        if (r_phase == PH_UPPER) begin
            w_dyl = DW'(r_vy[1]) - DW'(r_vy[0]);
            w_dxl = DW'(r_vx[1]) - DW'(r_vx[0]);
            w_xs  = r_vx[0];
        end else begin
            w_dyl = DW'(r_vy[2]) - DW'(r_vy[1]);
            w_dxl = DW'(r_vx[2]) - DW'(r_vx[1]);
            w_xs  = r_vx[1];
        end
        w_dyr = DW'(r_vy[2]) - DW'(r_vy[0]);
        w_dxr = DW'(r_vx[2]) - DW'(r_vx[0]);
    end

    tsg_div #(.NW(AW), .DW(DW)) u_div_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_num   (r_lacc),
        .i_den   (w_dyl),
        .o_busy  (w_busy_l),
        .o_quot  (w_ql)
    );

    tsg_div #(.NW(AW), .DW(DW)) u_div_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_num   (r_racc),
        .i_den   (w_dyr),
        .o_busy  (w_busy_r),
        .o_quot  (w_qr)
    );

    // span ends: flat extent or edge positions
    always_comb begin
        w_fmin = r_vx[0];
        w_fmax = r_vx[0];
        if (r_vx[1] < w_fmin) w_fmin = r_vx[1];
        if (r_vx[1] > w_fmax) w_fmax = r_vx[1];
        if (r_vx[2] < w_fmin) w_fmin = r_vx[2];
        if (r_vx[2] > w_fmax) w_fmax = r_vx[2];
        if (r_phase == PH_FLAT) begin
            w_a    = XW'(w_fmin);
            w_b    = XW'(w_fmax);
            w_last = 1'b1;
        end else begin
            w_a    = XW'(w_xs) + XW'(w_ql);
            w_b    = XW'(r_vx[0]) + XW'(w_qr);
            w_last = (r_row >= r_vy[2]);
        end
        w_next_row = (CW+1)'(r_row) + 1'b1;
    end

    tsg_clip #(.CW(CW)) u_clip (
        .i_a       (w_a),
        .i_b       (w_b),
        .i_row     (r_row),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_left    (w_left),
        .o_right   (w_right),
        .o_visible (w_vis)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(RESET_WIDTH);
            r_height <= CFG_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, triangle state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
            r_lacc      <= '0;
            r_racc      <= '0;
            r_row       <= '0;
            r_uend      <= '0;
            r_color     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_vx[i] <= '0;
                r_vy[i] <= '0;
            end
        end else begin
            // output valid: set on a new span, cleared when taken
            if (w_emit) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (t_cmd'(i_cmd) == CMD_LOAD) begin
                            for (int i = 0; i < 3; i++) begin
                                r_vx[i] <= s_x[i];
                                r_vy[i] <= s_y[i];
                            end
                            r_color <= i_fill_color;
                            r_row   <= s_y[0];
                            r_lacc  <= '0;
                            r_racc  <= '0;
                            r_uend  <= (s_y[1] == s_y[2]) ? s_y[1] : s_y[1] - 1'b1;
                            if (s_y[0] == s_y[2]) r_phase <= PH_FLAT;
                            else if (s_y[0] == s_y[1]) r_phase <= PH_LOWER;
                            else r_phase <= PH_UPPER;
                        end else if (r_phase == PH_FLAT) begin
                            r_state <= S_EMIT;
                        end else if (r_phase != PH_IDLE) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (!w_busy_l && !w_busy_r) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        o_span_row   <= r_row;
                        o_span_left  <= w_left;
                        o_span_right <= w_right;
                        o_visible    <= w_vis;
                        o_span_color <= r_color;
                        o_last_span  <= w_last;
                        r_state      <= S_IDLE;
                        r_row        <= w_next_row[CW-1:0];
                        r_racc       <= r_racc + AW'(w_dxr);
                        if (w_last) begin
                            r_phase <= PH_IDLE;
                        end else if (r_phase == PH_UPPER
                                     && w_next_row > (CW+1)'(r_uend)) begin
                            r_phase <= PH_LOWER;
                            r_lacc  <= '0;
                        end else begin
                            r_lacc  <= r_lacc + AW'(w_dxl);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // dividers only run while a tick is in work
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_busy_l && !w_busy_r))
        else $error("edge divider busy while idle");

    // a waiting span is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(o_span_row)
                                           && $stable(o_span_left)))
        else $error("pending span overwritten");

    // invisible spans carry zero columns
    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_visible) |-> (o_span_left == '0 && o_span_right == '0))
        else $error("invisible span with nonzero columns");

    // a flat triangle ends with its only span
    a_flat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_phase == PH_FLAT) |=> (o_last_span && r_phase == PH_IDLE))
        else $error("flat span not marked last");

endmodule

@@ rtl/tsg_div.sv @@
// bit-serial signed divider, quotient truncated toward zero, zero for divisor <= 0
module tsg_div import tsg_pkg::*; #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic                 o_busy,
    output logic signed [DW-1:0] o_quot
);
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_dvd;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic             r_neg;
    logic             r_zero;

    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_qbit;
    logic [DW-1:0]    w_mag;

    // one remainder step per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[NW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_qbit  = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    // operand and shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_rem  <= '0;
            r_den  <= DW'(i_den);
            r_neg  <= i_num[NW-1];
            r_zero <= (i_den <= 0);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NW-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign w_mag  = r_dvd[DW-1:0];
    assign o_busy = r_busy;
    assign o_quot = r_zero ? '0 : (r_neg ? -$signed(w_mag) : $signed(w_mag));

endmodule

@@ rtl/tsg_clip.sv @@
// clips one span against the screen and flags visibility
module tsg_clip import tsg_pkg::*; #(
    parameter int CW = TSG_COORD_WIDTH
) (
    input  logic signed [CW+1:0]  i_a,
    input  logic signed [CW+1:0]  i_b,
    input  logic signed [CW-1:0]  i_row,
    input  logic [CFG_W-1:0]      i_width,
    input  logic [CFG_W-1:0]      i_height,
    output logic [COL_W-1:0]      o_left,
    output logic [COL_W-1:0]      o_right,
    output logic                  o_visible
);
    localparam int XW = CW + 2;
    localparam int EW = ((XW > CFG_W + 1) ? XW : CFG_W + 1) + 1;

    logic signed [EW-1:0] w_a, w_b, w_lo, w_hi, w_w, w_h, w_row, w_l, w_r;

    always_comb begin
        w_a   = EW'(i_a);
        w_b   = EW'(i_b);
        w_row = EW'(i_row);
        w_w   = (i_width  > CFG_W'(MAX_SCREEN)) ? EW'(MAX_SCREEN) : EW'({1'b0, i_width});
        w_h   = (i_height > CFG_W'(MAX_SCREEN)) ? EW'(MAX_SCREEN) : EW'({1'b0, i_height});
        // order the ends
        if (w_a > w_b) begin
            w_lo = w_b;
            w_hi = w_a;
        end else begin
            w_lo = w_a;
            w_hi = w_b;
        end
        o_visible = (w_w > 0) && (w_h > 0) && (w_row >= 0) && (w_row < w_h)
                  && (w_lo < w_w) && (w_hi >= 0);
        w_l = (w_lo < 0) ? '0 : w_lo;
        w_r = (w_hi >= w_w) ? w_w - 1 : w_hi;
        o_left  = o_visible ? w_l[COL_W-1:0] : '0;
        o_right = o_visible ? w_r[COL_W-1:0] : '0;
    end

endmodule
